[sv/grid_ray_horizontal_caster_defines.svh]
// Assertion macros shared by the caster top level.
// Depends on nothing; expects clk and arst_n in the including scope.
`ifndef GRID_RAY_HORIZONTAL_CASTER_DEFINES_SVH
`define GRID_RAY_HORIZONTAL_CASTER_DEFINES_SVH
`define GRC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[sv/grc_pkg.sv]
// Shared constants, command and status types, and helper functions of the caster.
// Depends on nothing.
package grc_pkg;
	localparam int MAP_SIZE    = 16;
	localparam int MAP_BITS    = 4;
	localparam int CELL_W      = 2;
	localparam int FRAC_BITS   = 8;
	localparam int CELL_SHIFT  = FRAC_BITS + 6;
	localparam int CORDIC_ITERS = 15;
	localparam int DIV_BITS    = 48;

	localparam logic [1:0] CELL_WALL   = 2'd1;
	localparam logic [1:0] CELL_SPRITE = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	typedef struct packed {
		logic load;
		logic cordic;
		logic div_init;
		logic div_step;
		logic cot;
		logic mul;
		logic xset;
		logic look;
		logic check;
		logic final_emit;
	} cmd_t;

	typedef struct packed {
		logic cordic_done;
		logic div_done;
		logic stop;
	} status_t;

	function automatic logic signed [17:0] atan_turn(input logic [3:0] i);
		unique case (i)
			4'd0: atan_turn = 18'sd8192;
			4'd1: atan_turn = 18'sd4836;
			4'd2: atan_turn = 18'sd2555;
			4'd3: atan_turn = 18'sd1297;
			4'd4: atan_turn = 18'sd651;
			4'd5: atan_turn = 18'sd326;
			4'd6: atan_turn = 18'sd163;
			4'd7: atan_turn = 18'sd81;
			4'd8: atan_turn = 18'sd41;
			4'd9: atan_turn = 18'sd20;
			4'd10: atan_turn = 18'sd10;
			4'd11: atan_turn = 18'sd5;
			4'd12: atan_turn = 18'sd3;
			default: atan_turn = 18'sd1;
		endcase
	endfunction

	function automatic logic signed [19:0] clamp20(input logic signed [33:0] v);
		if (v > 34'sd524287) clamp20 = 20'sd524287;
		else if (v < -34'sd524288) clamp20 = -20'sd524288;
		else clamp20 = v[19:0];
	endfunction

	function automatic logic out20(input logic signed [33:0] v);
		out20 = (v > 34'sd524287) || (v < -34'sd524288);
	endfunction
endpackage

[sv/grc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module grc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[sv/grc_ctrl.sv]
// Controller state machine that sequences setup, division and the row walk.
// Depends on grc_pkg.
module grc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             operation,
	input  grc_pkg::status_t status,
	output grc_pkg::cmd_t    cmd,
	output logic             busy
);
	typedef enum logic [3:0] {
		S_IDLE, S_CORD, S_DIVI, S_DIV, S_COT, S_MUL, S_XSET, S_LOOK, S_CHECK, S_FINAL
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start && operation == grc_pkg::OP_CAST) begin
						state_q <= S_CORD;
						busy_q  <= 1'b1;
					end
				end
				S_CORD: if (status.cordic_done) state_q <= S_DIVI;
				S_DIVI: state_q <= S_DIV;
				S_DIV: if (status.div_done) state_q <= S_COT;
				S_COT: state_q <= S_MUL;
				S_MUL: state_q <= S_XSET;
				S_XSET: state_q <= S_LOOK;
				S_LOOK: state_q <= S_CHECK;
				S_CHECK: state_q <= status.stop ? S_FINAL : S_LOOK;
				S_FINAL: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && start && operation == grc_pkg::OP_CAST;
		cmd.cordic     = state_q == S_CORD;
		cmd.div_init   = state_q == S_DIVI;
		cmd.div_step   = state_q == S_DIV;
		cmd.cot        = state_q == S_COT;
		cmd.mul        = state_q == S_MUL;
		cmd.xset       = state_q == S_XSET;
		cmd.look       = state_q == S_LOOK;
		cmd.check      = state_q == S_CHECK;
		cmd.final_emit = state_q == S_FINAL;
	end

	assign busy = busy_q;
endmodule

[sv/grc_dp.sv]
// Datapath: CORDIC, restoring divider, first-crossing setup, row walk and result registers.
// Depends on grc_pkg and grc_ram.
module grc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  grc_pkg::cmd_t       cmd,
	output grc_pkg::status_t    status,
	input  logic                map_we,
	input  logic [3:0]          cell_row,
	input  logic [3:0]          cell_col,
	input  logic [1:0]          cell_kind,
	input  logic [17:0]         player_x,
	input  logic [17:0]         player_y,
	input  logic [11:0]         angle,
	output logic                result_valid,
	output logic                is_sprite,
	output logic signed [11:0]  sprite_x,
	output logic signed [11:0]  sprite_y,
	output logic signed [19:0]  hit_x,
	output logic signed [19:0]  hit_y,
	output logic [7:0]          tex_offset,
	output logic                saturated,
	output logic                last
);
	localparam int DEPTH = grc_pkg::MAP_SIZE * grc_pkg::MAP_SIZE;
	localparam int AW = 2 * grc_pkg::MAP_BITS;

	logic [17:0]        px_q, py_q;
	logic [11:0]        a_q;
	logic signed [17:0] z_q;
	logic signed [31:0] cx_q, cy_q;
	logic [3:0]         it_q;
	logic [47:0]        num_q, quo_q;
	logic [32:0]        rem_q;
	logic [31:0]        den_q;
	logic               neg_q, yzero_q;
	logic [5:0]         cnt_q;
	logic signed [27:0] cot_q;
	logic signed [19:0] ay_q, ax_q, rel_q;
	logic signed [25:0] dx_q;
	logic signed [31:0] prod_q;
	logic               up_q, left_q, sat_q;
	logic [4:0]         n_q, steps_q;
	logic               oob_q;
	logic [3:0]         r_q, c_q;
	logic [DEPTH-1:0]   vld_q;
	logic               vrd_q;
	logic [1:0]         ram_rdata;
	logic [AW-1:0]      raddr;

	logic signed [5:0]  r_w;
	logic signed [6:0]  c_w;
	logic [15:0]        t16;
	logic signed [31:0] shx, shy;
	logic [32:0]        rem_n;
	logic [31:0]        absx, absy;
	logic [26:0]        qmag;
	logic signed [47:0] mprod;
	logic signed [33:0] axn, ayn, axs;
	logic [1:0]         map_kind;
	logic [4:0]         row0;

	assign t16   = {angle, 4'b0} + 16'd16384;
	assign shx   = cx_q >>> it_q;
	assign shy   = cy_q >>> it_q;
	assign rem_n = {rem_q[31:0], num_q[47]};
	assign absx  = cx_q[31] ? 32'(-cx_q) : 32'(cx_q);
	assign absy  = cy_q[31] ? 32'(-cy_q) : 32'(cy_q);
	assign qmag  = (quo_q > 48'd67108864) ? 27'd67108864 : quo_q[26:0];
	assign mprod = 48'(rel_q) * 48'(cot_q);
	assign axs   = 34'(px_q) + 34'(prod_q);
	assign axn   = 34'(ax_q) + 34'(dx_q);
	assign ayn   = 34'(ay_q) + (up_q ? -34'sd16384 : 34'sd16384);
	assign row0  = {1'b0, py_q[17:grc_pkg::CELL_SHIFT]};
	assign r_w   = 6'(ay_q >>> grc_pkg::CELL_SHIFT);
	assign c_w   = 7'(ax_q >>> grc_pkg::CELL_SHIFT)
		+ 7'((left_q && ax_q[13:0] >= 14'd16128) ? 1 : 0);
	assign raddr = {r_w[3:0], c_w[3:0]};
	assign map_kind = vrd_q ? ram_rdata : 2'd0;

	assign status.cordic_done = it_q == 4'(grc_pkg::CORDIC_ITERS - 1);
	assign status.div_done    = cnt_q == 6'(grc_pkg::DIV_BITS - 1);
	assign status.stop        = oob_q || map_kind == grc_pkg::CELL_WALL
		|| steps_q == 5'(grc_pkg::MAP_SIZE);

	grc_ram #(.WIDTH(grc_pkg::CELL_W), .DEPTH(DEPTH)) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr({cell_row, cell_col}),
		.wdata(cell_kind),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			if (map_we) vld_q[{cell_row, cell_col}] <= 1'b1;
			result_valid <= (cmd.check && !oob_q && map_kind == grc_pkg::CELL_SPRITE
				&& n_q < 5'(grc_pkg::MAP_SIZE)) || cmd.final_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q   <= player_x;
			py_q   <= player_y;
			a_q    <= angle;
			z_q    <= $signed({3'b0, t16[14:0]}) - 18'sd16384;
			cx_q   <= 32'sd268435456;
			cy_q   <= '0;
			it_q   <= '0;
			sat_q  <= 1'b0;
			n_q    <= '0;
			steps_q <= '0;
		end
		if (cmd.cordic) begin
			if (!z_q[17]) begin
				cx_q <= cx_q - shy;
				cy_q <= cy_q + shx;
				z_q  <= z_q - grc_pkg::atan_turn(it_q);
			end else begin
				cx_q <= cx_q + shy;
				cy_q <= cy_q - shx;
				z_q  <= z_q + grc_pkg::atan_turn(it_q);
			end
			it_q <= it_q + 4'd1;
		end
		if (cmd.div_init) begin
			num_q   <= {absx, 16'b0};
			den_q   <= absy;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= cx_q[31] ^ cy_q[31];
			yzero_q <= cy_q == 32'sd0;
		end
		if (cmd.div_step) begin
			if (rem_n >= {1'b0, den_q}) begin
				rem_q <= rem_n - {1'b0, den_q};
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= rem_n;
				quo_q <= {quo_q[46:0], 1'b0};
			end
			num_q <= {num_q[46:0], 1'b0};
			cnt_q <= cnt_q + 6'd1;
		end
		if (cmd.cot) begin
			if (yzero_q) cot_q <= 28'sd67108864;
			else cot_q <= neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
			up_q   <= a_q < 12'd2048;
			left_q <= a_q > 12'd1024 && a_q < 12'd3072 && a_q != 12'd2048;
			if (a_q < 12'd2048) begin
				ay_q  <= $signed({1'b0, row0, 14'b0}) - 20'sd256;
				rel_q <= $signed({2'b0, py_q}) - ($signed({1'b0, row0, 14'b0}) - 20'sd256);
			end else begin
				ay_q  <= $signed({1'b0, row0, 14'b0}) + 20'sd16384;
				rel_q <= $signed({2'b0, py_q}) - ($signed({1'b0, row0, 14'b0}) + 20'sd16384);
			end
		end
		if (cmd.mul) begin
			prod_q <= 32'((mprod + 48'sd32768) >>> 16);
			dx_q   <= (a_q > 12'd2048) ? -26'((cot_q + 28'sd2) >>> 2)
				: 26'((cot_q + 28'sd2) >>> 2);
		end
		if (cmd.xset) begin
			ax_q  <= grc_pkg::clamp20(axs);
			sat_q <= sat_q | grc_pkg::out20(axs);
		end
		if (cmd.look) begin
			oob_q <= r_w < 6'sd0 || r_w >= 6'(grc_pkg::MAP_SIZE)
				|| c_w < 7'sd0 || c_w >= 7'(grc_pkg::MAP_SIZE);
			r_q   <= r_w[3:0];
			c_q   <= c_w[3:0];
			vrd_q <= vld_q[raddr];
		end
		if (cmd.check) begin
			is_sprite  <= 1'b1;
			sprite_x   <= $signed({2'b0, c_q, 6'b0}) - 12'sd32;
			sprite_y   <= $signed({2'b0, r_q, 6'b0}) - 12'sd32;
			hit_x      <= '0;
			hit_y      <= '0;
			tex_offset <= '0;
			saturated  <= 1'b0;
			last       <= 1'b0;
			if (!oob_q && map_kind == grc_pkg::CELL_SPRITE && n_q < 5'(grc_pkg::MAP_SIZE))
				n_q <= n_q + 5'd1;
			if (!status.stop) begin
				ax_q    <= grc_pkg::clamp20(axn);
				ay_q    <= grc_pkg::clamp20(ayn);
				sat_q   <= sat_q | grc_pkg::out20(axn) | grc_pkg::out20(ayn);
				steps_q <= steps_q + 5'd1;
			end
		end
		if (cmd.final_emit) begin
			is_sprite  <= 1'b0;
			sprite_x   <= '0;
			sprite_y   <= '0;
			hit_x      <= ax_q;
			hit_y      <= ay_q;
			tex_offset <= ax_q[13:6];
			saturated  <= sat_q;
			last       <= 1'b1;
		end
	end
endmodule

[sv/grid_ray_horizontal_caster.sv]
// Top level of the horizontal grid-line ray caster.
// Depends on grc_pkg, grc_ctrl, grc_dp and the assertion header.
//
// A map write leaves busy low. A cast first runs its setup (15 CORDIC
// iterations and a bit-serial divider with a 48-bit quotient for the
// cotangent, then the first crossing), then examines cells, with one map
// read and one check per cell, for at most 17 cells, then emits the final
// result. Each result shows for exactly one cycle on result_valid and must be
// taken then; sprite results come while busy is high, the final one with last
// set in the cycle busy drops, when the next transfer may already start.
`include "grid_ray_horizontal_caster_defines.svh"
module grid_ray_horizontal_caster (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [3:0]         cell_row,
	input  logic [3:0]         cell_col,
	input  logic [1:0]         cell_kind,
	input  logic [17:0]        player_x,
	input  logic [17:0]        player_y,
	input  logic [11:0]        angle,
	output logic               result_valid,
	output logic               is_sprite,
	output logic signed [11:0] sprite_x,
	output logic signed [11:0] sprite_y,
	output logic signed [19:0] hit_x,
	output logic signed [19:0] hit_y,
	output logic [7:0]         tex_offset,
	output logic               saturated,
	output logic               last
);
	grc_pkg::cmd_t    cmd;
	grc_pkg::status_t status;
	logic             map_we;

	assign map_we = start && !busy && operation == grc_pkg::OP_WRITE;

	grc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .operation(operation),
		.status(status), .cmd(cmd), .busy(busy)
	);

	grc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .map_we(map_we),
		.cell_row(cell_row), .cell_col(cell_col), .cell_kind(cell_kind),
		.player_x(player_x), .player_y(player_y), .angle(angle),
		.result_valid(result_valid), .is_sprite(is_sprite),
		.sprite_x(sprite_x), .sprite_y(sprite_y), .hit_x(hit_x), .hit_y(hit_y),
		.tex_offset(tex_offset), .saturated(saturated), .last(last)
	);

	`GRC_ASSERT_SAME(a_sprite_busy, result_valid && !last, busy, "sprite result while idle")
	`GRC_ASSERT_SAME(a_final_idle, result_valid && last, !busy, "final result while busy")
	`GRC_ASSERT_NEXT(a_cast_busy, start && !busy && operation == grc_pkg::OP_CAST, busy, "cast did not start")
endmodule
